[design/gmwl_pkg.sv]
// ----------------------------------------------------------------------------
// gmwl_pkg
// shared widths, limits and codes for the grid mesh warp lookup
// ----------------------------------------------------------------------------
package gmwl_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;

  localparam int COORD_W  = 24;
  localparam int SPAN_W   = COORD_W + 1;
  localparam int FRAC_W   = 16;
  localparam int CNT_W    = 7;
  localparam int CELL_W   = $clog2((MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS);
  localparam int QUO_W    = CELL_W + FRAC_W;
  localparam int STORE_AW = 12;

  localparam int IN_TDATA_W  = ((STORE_AW + 6 * COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * COORD_W + 7) / 8) * 8;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = CFG_IDX_W'(1);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

[design/grid_mesh_warp_lookup_top.sv]
// ----------------------------------------------------------------------------
// grid_mesh_warp_lookup_top
// piecewise linear warp lookup over a triangulated grid of mesh nodes
// ----------------------------------------------------------------------------
// Takes one word per clock, load or query, while the output is not held
// back by out_tready, and raises out_tvalid with the mapped texture
// coordinate of each query; loads give no word. The path is 33 register
// stages: five before the 22-stage restoring divider that finds cell and
// fraction on each axis, one quotient bit per stage, and six after it
// (memory read, interpolation, output register). Node positions and texture
// coordinates live in separate memories, written at the pipeline stage where
// they are read, so every query sees exactly the loads accepted before it.
// Memories are not cleared after reset; a node must be loaded before a query
// can touch it. The user writes grid size only while idle; no check enforces it.
// ----------------------------------------------------------------------------
module grid_mesh_warp_lookup_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // node_index, node_pos_x, node_pos_y, node_tex_u, node_tex_v, query_x, query_y
  input  logic [gmwl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // mapped_u, mapped_v
  output logic [gmwl_pkg::OUT_TDATA_W-1:0] out_tdata,
  // inside_res
  output logic [0:0]                       out_tuser,
  input  logic                             cfg_we,
  input  logic [gmwl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gmwl_pkg::CNT_W-1:0]       cfg_wdata
);

  localparam int CW  = gmwl_pkg::COORD_W;
  localparam int SW  = gmwl_pkg::SPAN_W;
  localparam int DW  = SW + 1;
  localparam int FW  = gmwl_pkg::FRAC_W;
  localparam int CLW = gmwl_pkg::CELL_W;
  localparam int QW  = gmwl_pkg::QUO_W;
  localparam int NTW = gmwl_pkg::CNT_W;
  localparam int AW  = gmwl_pkg::STORE_AW;
  localparam int NW  = DW + CLW + 1;
  localparam int LW  = SW + CLW;
  localparam int WW  = FW + 2;
  localparam int PW  = WW + SW;
  localparam int ACW = PW + 3;
  localparam int BW  = CLW + NTW + 1;

  localparam logic [ACW:0]      HALF_LSB = (ACW + 1)'(1) << (FW - 1);
  localparam logic [ACW-FW+1:0] ONE_Q    = (ACW - FW + 2)'(1) << FW;
  localparam logic [FW:0]       ONE_F    = (FW + 1)'(1) << FW;

  typedef struct packed {
    logic          v;
    logic          load;
    logic [AW-1:0] idx;
    logic [CW-1:0] tu;
    logic [CW-1:0] tv;
    logic [CW-1:0] qx;
    logic [CW-1:0] qy;
    logic [CW-1:0] lox;
    logic [CW-1:0] loy;
  } s1_t;

  typedef struct packed {
    logic          v;
    logic          load;
    logic [AW-1:0] idx;
    logic [CW-1:0] tu;
    logic [CW-1:0] tv;
    logic [SW-1:0] dx;
    logic [SW-1:0] dy;
    logic [SW-1:0] spx;
    logic [SW-1:0] spy;
  } s2_t;

  typedef struct packed {
    logic          v;
    logic          load;
    logic [AW-1:0] idx;
    logic [CW-1:0] tu;
    logic [CW-1:0] tv;
    logic [DW-1:0] dnx;
    logic [DW-1:0] dny;
    logic [SW-1:0] sax;
    logic [SW-1:0] say;
    logic          zero;
  } s3_t;

  typedef struct packed {
    logic          v;
    logic          load;
    logic [AW-1:0] idx;
    logic [CW-1:0] tu;
    logic [CW-1:0] tv;
    logic [NW-1:0] numx;
    logic [NW-1:0] numy;
    logic [LW-1:0] limx;
    logic [LW-1:0] limy;
    logic [SW-1:0] sax;
    logic [SW-1:0] say;
    logic          zero;
  } s4_t;

  typedef struct packed {
    logic          v;
    logic          load;
    logic [AW-1:0] idx;
    logic [CW-1:0] tu;
    logic [CW-1:0] tv;
    logic          in_grid;
  } sb_t;

  typedef struct packed {
    sb_t           sb;
    logic [SW-1:0] remx;
    logic [SW-1:0] remy;
    logic [QW-1:0] bitsx;
    logic [QW-1:0] bitsy;
    logic [SW-1:0] dsrx;
    logic [SW-1:0] dsry;
  } s5_t;

  typedef struct packed {
    logic          v;
    logic          load;
    logic [AW-1:0] idx;
    logic [CW-1:0] tu;
    logic [CW-1:0] tv;
    logic          in_grid;
    logic [AW-1:0] base;
    logic [FW-1:0] fx;
    logic [FW-1:0] fy;
    logic          lower;
  } a1_t;

  typedef struct packed {
    logic          v;
    logic          in_grid;
    logic          lower;
    logic [FW-1:0] fx;
    logic [FW-1:0] fy;
  } a2_t;

  typedef struct packed {
    logic          v;
    logic          in_grid;
    logic [CW-1:0] ua;
    logic [CW-1:0] va;
    logic [SW-1:0] ub;
    logic [SW-1:0] uc;
    logic [SW-1:0] vb;
    logic [SW-1:0] vc;
    logic [WW-1:0] wx;
    logic [WW-1:0] wy;
  } m1_t;

  typedef struct packed {
    logic          v;
    logic          in_grid;
    logic [CW-1:0] ua;
    logic [CW-1:0] va;
    logic [PW-1:0] pub;
    logic [PW-1:0] puc;
    logic [PW-1:0] pvb;
    logic [PW-1:0] pvc;
  } m2_t;

  typedef struct packed {
    logic           v;
    logic           in_grid;
    logic [ACW-1:0] accu;
    logic [ACW-1:0] accv;
  } m3_t;

  function automatic logic [NTW-1:0] clamp_cnt(input logic [NTW-1:0] c,
                                                input logic [NTW-1:0] hi);
    logic [NTW-1:0] r;
    if (c < NTW'(2)) begin
      r = NTW'(2);
    end else if (c > hi) begin
      r = hi;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] sx(input logic [CW-1:0] a);
    return {a[CW-1], a};
  endfunction

  function automatic logic [CW-1:0] finish_q(input logic [ACW-1:0] acc);
    logic [ACW:0]      t;
    logic [ACW-FW:0]   f;
    logic [ACW-FW+1:0] r;
    logic [CW-1:0]     q;
    t = {acc, 1'b0} + HALF_LSB;
    f = t[ACW:FW];
    r = {f[ACW-FW], f} - ONE_Q;
    if ((&r[ACW-FW+1:CW-1]) || !(|r[ACW-FW+1:CW-1])) begin
      q = r[CW-1:0];
    end else if (r[ACW-FW+1]) begin
      q = {1'b1, {(CW-1){1'b0}}};
    end else begin
      q = {1'b0, {(CW-1){1'b1}}};
    end
    return q;
  endfunction

  // configuration
  logic [NTW-1:0] cols_r;
  logic [NTW-1:0] rows_r;
  logic [NTW-1:0] nx;
  logic [NTW-1:0] ny;
  logic [CLW-1:0] nm1x;
  logic [CLW-1:0] nm1y;
  logic [2*NTW-1:0] cnt_prod;
  logic [AW-1:0]  last_idx;

  assign nx       = clamp_cnt(cols_r, NTW'(gmwl_pkg::MAX_COLUMNS));
  assign ny       = clamp_cnt(rows_r, NTW'(gmwl_pkg::MAX_ROWS));
  assign nm1x     = CLW'(nx - NTW'(1));
  assign nm1y     = CLW'(ny - NTW'(1));
  assign cnt_prod = nx * ny;
  assign last_idx = cnt_prod[AW-1:0] - AW'(1);

  logic en;
  logic acc;
  logic in_load;
  logic [AW-1:0] in_idx;
  logic [CW-1:0] in_px;
  logic [CW-1:0] in_py;

  logic          o_vld_r;
  logic [CW-1:0] o_u_r;
  logic [CW-1:0] o_v_r;
  logic          o_in_r;

  assign en        = !o_vld_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;
  assign in_load   = (in_tuser[0] == gmwl_pkg::MODE_LOAD);
  assign in_idx    = in_tdata[AW-1:0];
  assign in_px     = in_tdata[AW +: CW];
  assign in_py     = in_tdata[AW+CW +: CW];

  // first node position kept in registers, last node read from memory
  logic [CW-1:0]   n0x_r;
  logic [CW-1:0]   n0y_r;
  logic [2*CW-1:0] pos_last;

  always_ff @(posedge clk) begin
    if (acc && in_load && (in_idx == AW'(0))) begin
      n0x_r <= in_px;
      n0y_r <= in_py;
    end
  end

  gmwl_ram #(.AW(AW), .DW(2 * CW)) u_pos_ram (
    .clk   (clk),
    .we    (acc && in_load),
    .waddr (in_idx),
    .wdata ({in_py, in_px}),
    .re    (en),
    .raddr (last_idx),
    .rdata (pos_last)
  );

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  sb_t sb_r [QW];
  a1_t a1_r, a1_nxt;
  a2_t a2_r, a2_nxt;
  m1_t m1_r, m1_nxt;
  m2_t m2_r, m2_nxt;
  m3_t m3_r, m3_nxt;

  logic [QW-1:0] quo_x;
  logic [QW-1:0] quo_y;

  logic          negx;
  logic          negy;
  logic [DW-1:0] dxe;
  logic [DW-1:0] dye;

  always_comb begin
    s1_nxt.v    = in_tvalid;
    s1_nxt.load = in_load;
    s1_nxt.idx  = in_idx;
    s1_nxt.tu   = in_tdata[AW+2*CW +: CW];
    s1_nxt.tv   = in_tdata[AW+3*CW +: CW];
    s1_nxt.qx   = in_tdata[AW+4*CW +: CW];
    s1_nxt.qy   = in_tdata[AW+5*CW +: CW];
    s1_nxt.lox  = n0x_r;
    s1_nxt.loy  = n0y_r;

    s2_nxt.v    = s1_r.v;
    s2_nxt.load = s1_r.load;
    s2_nxt.idx  = s1_r.idx;
    s2_nxt.tu   = s1_r.tu;
    s2_nxt.tv   = s1_r.tv;
    s2_nxt.dx   = sx(s1_r.qx) - sx(s1_r.lox);
    s2_nxt.dy   = sx(s1_r.qy) - sx(s1_r.loy);
    s2_nxt.spx  = sx(pos_last[CW-1:0]) - sx(s1_r.lox);
    s2_nxt.spy  = sx(pos_last[2*CW-1:CW]) - sx(s1_r.loy);

    // a negative span flips both signs
    negx        = s2_r.spx[SW-1];
    negy        = s2_r.spy[SW-1];
    dxe         = {s2_r.dx[SW-1], s2_r.dx};
    dye         = {s2_r.dy[SW-1], s2_r.dy};
    s3_nxt.v    = s2_r.v;
    s3_nxt.load = s2_r.load;
    s3_nxt.idx  = s2_r.idx;
    s3_nxt.tu   = s2_r.tu;
    s3_nxt.tv   = s2_r.tv;
    s3_nxt.dnx  = negx ? -dxe : dxe;
    s3_nxt.dny  = negy ? -dye : dye;
    s3_nxt.sax  = negx ? -s2_r.spx : s2_r.spx;
    s3_nxt.say  = negy ? -s2_r.spy : s2_r.spy;
    s3_nxt.zero = (s2_r.spx == '0) || (s2_r.spy == '0);

    s4_nxt.v    = s3_r.v;
    s4_nxt.load = s3_r.load;
    s4_nxt.idx  = s3_r.idx;
    s4_nxt.tu   = s3_r.tu;
    s4_nxt.tv   = s3_r.tv;
    s4_nxt.numx = $signed(s3_r.dnx) * $signed({1'b0, nm1x});
    s4_nxt.numy = $signed(s3_r.dny) * $signed({1'b0, nm1y});
    s4_nxt.limx = s3_r.sax * nm1x;
    s4_nxt.limy = s3_r.say * nm1y;
    s4_nxt.sax  = s3_r.sax;
    s4_nxt.say  = s3_r.say;
    s4_nxt.zero = s3_r.zero;

    s5_nxt.sb.v       = s4_r.v;
    s5_nxt.sb.load    = s4_r.load;
    s5_nxt.sb.idx     = s4_r.idx;
    s5_nxt.sb.tu      = s4_r.tu;
    s5_nxt.sb.tv      = s4_r.tv;
    s5_nxt.sb.in_grid = !s4_r.zero
                        && !s4_r.numx[NW-1] && (s4_r.numx[NW-2:0] < {1'b0, s4_r.limx})
                        && !s4_r.numy[NW-1] && (s4_r.numy[NW-2:0] < {1'b0, s4_r.limy});
    s5_nxt.remx  = s4_r.numx[CLW +: SW];
    s5_nxt.remy  = s4_r.numy[CLW +: SW];
    s5_nxt.bitsx = {s4_r.numx[CLW-1:0], {FW{1'b0}}};
    s5_nxt.bitsy = {s4_r.numy[CLW-1:0], {FW{1'b0}}};
    s5_nxt.dsrx  = s4_r.sax;
    s5_nxt.dsry  = s4_r.say;
  end

  gmwl_div u_div_x (
    .clk     (clk),
    .en      (en),
    .rem_in  (s5_r.remx),
    .bits_in (s5_r.bitsx),
    .dsr_in  (s5_r.dsrx),
    .quo_out (quo_x)
  );

  gmwl_div u_div_y (
    .clk     (clk),
    .en      (en),
    .rem_in  (s5_r.remy),
    .bits_in (s5_r.bitsy),
    .dsr_in  (s5_r.dsry),
    .quo_out (quo_y)
  );

  // cell base and triangle choice
  logic [CLW-1:0] cx;
  logic [CLW-1:0] cy;
  logic [FW-1:0]  fx;
  logic [FW-1:0]  fy;
  logic [BW-1:0]  base_full;

  always_comb begin
    cx        = quo_x[QW-1:FW];
    cy        = quo_y[QW-1:FW];
    fx        = quo_x[FW-1:0];
    fy        = quo_y[FW-1:0];
    base_full = cy * nx + BW'(cx);

    a1_nxt.v       = sb_r[QW-1].v;
    a1_nxt.load    = sb_r[QW-1].load;
    a1_nxt.idx     = sb_r[QW-1].idx;
    a1_nxt.tu      = sb_r[QW-1].tu;
    a1_nxt.tv      = sb_r[QW-1].tv;
    a1_nxt.in_grid = sb_r[QW-1].in_grid;
    a1_nxt.base    = base_full[AW-1:0];
    a1_nxt.fx      = fx;
    a1_nxt.fy      = fy;
    a1_nxt.lower   = ({1'b0, fx} + {1'b0, fy}) > ONE_F;
  end

  // texture store, one copy per cell corner
  logic [AW-1:0]   tex_addr [4];
  logic [2*CW-1:0] tex_q    [4];
  logic            tex_we;

  assign tex_we      = en && a1_r.v && a1_r.load;
  assign tex_addr[0] = a1_r.base;
  assign tex_addr[1] = a1_r.base + AW'(1);
  assign tex_addr[2] = a1_r.base + AW'(nx);
  assign tex_addr[3] = a1_r.base + AW'(nx) + AW'(1);

  for (genvar g = 0; g < 4; g++) begin : g_tex
    gmwl_ram #(.AW(AW), .DW(2 * CW)) u_tex_ram (
      .clk   (clk),
      .we    (tex_we),
      .waddr (a1_r.idx),
      .wdata ({a1_r.tv, a1_r.tu}),
      .re    (en),
      .raddr (tex_addr[g]),
      .rdata (tex_q[g])
    );
  end

  logic [CW-1:0] pu [4];
  logic [CW-1:0] pv [4];

  always_comb begin
    a2_nxt.v       = a1_r.v && !a1_r.load;
    a2_nxt.in_grid = a1_r.in_grid;
    a2_nxt.lower   = a1_r.lower;
    a2_nxt.fx      = a1_r.fx;
    a2_nxt.fy      = a1_r.fy;

    for (int g = 0; g < 4; g++) begin
      pu[g] = tex_q[g][CW-1:0];
      pv[g] = tex_q[g][2*CW-1:CW];
    end

    m1_nxt.v       = a2_r.v;
    m1_nxt.in_grid = a2_r.in_grid;
    if (a2_r.lower) begin
      m1_nxt.ua = pu[3];
      m1_nxt.va = pv[3];
      m1_nxt.ub = sx(pu[3]) - sx(pu[2]);
      m1_nxt.uc = sx(pu[3]) - sx(pu[1]);
      m1_nxt.vb = sx(pv[3]) - sx(pv[2]);
      m1_nxt.vc = sx(pv[3]) - sx(pv[1]);
      m1_nxt.wx = {2'b11, a2_r.fx};
      m1_nxt.wy = {2'b11, a2_r.fy};
    end else begin
      m1_nxt.ua = pu[0];
      m1_nxt.va = pv[0];
      m1_nxt.ub = sx(pu[1]) - sx(pu[0]);
      m1_nxt.uc = sx(pu[2]) - sx(pu[0]);
      m1_nxt.vb = sx(pv[1]) - sx(pv[0]);
      m1_nxt.vc = sx(pv[2]) - sx(pv[0]);
      m1_nxt.wx = {2'b00, a2_r.fx};
      m1_nxt.wy = {2'b00, a2_r.fy};
    end

    m2_nxt.v       = m1_r.v;
    m2_nxt.in_grid = m1_r.in_grid;
    m2_nxt.ua      = m1_r.ua;
    m2_nxt.va      = m1_r.va;
    m2_nxt.pub     = $signed(m1_r.wx) * $signed(m1_r.ub);
    m2_nxt.puc     = $signed(m1_r.wy) * $signed(m1_r.uc);
    m2_nxt.pvb     = $signed(m1_r.wx) * $signed(m1_r.vb);
    m2_nxt.pvc     = $signed(m1_r.wy) * $signed(m1_r.vc);

    m3_nxt.v       = m2_r.v;
    m3_nxt.in_grid = m2_r.in_grid;
    m3_nxt.accu    = {{(ACW-CW-FW){m2_r.ua[CW-1]}}, m2_r.ua, {FW{1'b0}}}
                     + {{(ACW-PW){m2_r.pub[PW-1]}}, m2_r.pub}
                     + {{(ACW-PW){m2_r.puc[PW-1]}}, m2_r.puc};
    m3_nxt.accv    = {{(ACW-CW-FW){m2_r.va[CW-1]}}, m2_r.va, {FW{1'b0}}}
                     + {{(ACW-PW){m2_r.pvb[PW-1]}}, m2_r.pvb}
                     + {{(ACW-PW){m2_r.pvc[PW-1]}}, m2_r.pvc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= NTW'(2);
      rows_r  <= NTW'(2);
      s1_r.v  <= 1'b0;
      s2_r.v  <= 1'b0;
      s3_r.v  <= 1'b0;
      s4_r.v  <= 1'b0;
      s5_r.sb.v <= 1'b0;
      for (int k = 0; k < QW; k++) begin
        sb_r[k].v <= 1'b0;
      end
      a1_r.v  <= 1'b0;
      a2_r.v  <= 1'b0;
      m1_r.v  <= 1'b0;
      m2_r.v  <= 1'b0;
      m3_r.v  <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gmwl_pkg::CFG_COLUMNS: cols_r <= cfg_wdata;
          gmwl_pkg::CFG_ROWS:    rows_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (en) begin
        s1_r    <= s1_nxt;
        s2_r    <= s2_nxt;
        s3_r    <= s3_nxt;
        s4_r    <= s4_nxt;
        s5_r    <= s5_nxt;
        sb_r[0] <= s5_r.sb;
        for (int k = 1; k < QW; k++) begin
          sb_r[k] <= sb_r[k-1];
        end
        a1_r    <= a1_nxt;
        a2_r    <= a2_nxt;
        m1_r    <= m1_nxt;
        m2_r    <= m2_nxt;
        m3_r    <= m3_nxt;
        o_vld_r <= m3_r.v;
        o_in_r  <= m3_r.in_grid;
        o_u_r   <= m3_r.in_grid ? finish_q(m3_r.accu) : '0;
        o_v_r   <= m3_r.in_grid ? finish_q(m3_r.accv) : '0;
      end
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {o_v_r, o_u_r};
  assign out_tuser  = o_in_r;

endmodule

[design/gmwl_ram.sv]
// ----------------------------------------------------------------------------
// gmwl_ram
// simple memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module gmwl_ram #(
  parameter int AW = 12,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/gmwl_div.sv]
// ----------------------------------------------------------------------------
// gmwl_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module gmwl_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gmwl_pkg::SPAN_W-1:0] rem_in,
  input  logic [gmwl_pkg::QUO_W-1:0]  bits_in,
  input  logic [gmwl_pkg::SPAN_W-1:0] dsr_in,
  output logic [gmwl_pkg::QUO_W-1:0]  quo_out
);

  localparam int SW = gmwl_pkg::SPAN_W;
  localparam int QW = gmwl_pkg::QUO_W;

  logic [SW-1:0] rem_r  [QW];
  logic [QW-1:0] bits_r [QW];
  logic [SW-1:0] dsr_r  [QW];
  logic [QW-1:0] quo_r  [QW];

  logic [SW-1:0] rem_src  [QW];
  logic [QW-1:0] bits_src [QW];
  logic [SW-1:0] dsr_src  [QW];
  logic [QW-1:0] quo_src  [QW];
  logic [SW:0]   trial    [QW];
  logic [SW:0]   diff     [QW];
  logic          ge       [QW];
  logic [SW-1:0] rem_nxt  [QW];
  logic [QW-1:0] bits_nxt [QW];
  logic [QW-1:0] quo_nxt  [QW];

  always_comb begin
    rem_src[0]  = rem_in;
    bits_src[0] = bits_in;
    dsr_src[0]  = dsr_in;
    quo_src[0]  = '0;
    for (int k = 1; k < QW; k++) begin
      rem_src[k]  = rem_r[k-1];
      bits_src[k] = bits_r[k-1];
      dsr_src[k]  = dsr_r[k-1];
      quo_src[k]  = quo_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      trial[k]    = {rem_src[k], bits_src[k][QW-1]};
      diff[k]     = trial[k] - {1'b0, dsr_src[k]};
      ge[k]       = trial[k] >= {1'b0, dsr_src[k]};
      rem_nxt[k]  = ge[k] ? diff[k][SW-1:0] : trial[k][SW-1:0];
      bits_nxt[k] = {bits_src[k][QW-2:0], 1'b0};
      quo_nxt[k]  = {quo_src[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        bits_r[k] <= bits_nxt[k];
        dsr_r[k]  <= dsr_src[k];
        quo_r[k]  <= quo_nxt[k];
      end
    end
  end

  assign quo_out = quo_r[QW-1];

endmodule
